>>> rtl/ppb_pkg.sv
package ppb_pkg;

  localparam int unsigned PortSlots = 4;
  localparam int unsigned SlotW     = $clog2(PortSlots);
  localparam int unsigned NumIrqs   = 3;
  localparam int unsigned CfgW      = 3;

  localparam logic [7:0] HiPrimary   = 8'h03;
  localparam logic [7:0] HiSecondary = 8'h02;
  localparam logic [5:0] MidPrimary  = 6'h1E;
  localparam logic [5:0] MidMono     = 6'h2F;

  typedef enum logic [1:0] {
    CMD_IO_WRITE = 2'd0,
    CMD_IO_READ  = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_DEV_LINE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DATA    = 2'd0,
    REG_STATUS  = 2'd1,
    REG_CONTROL = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_e;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
    reg_e             offset;
  } dec_t;

  typedef struct packed {
    logic               handled;
    logic [7:0]         read_data;
    logic               data_out_valid;
    logic [7:0]         data_out;
    logic               control_out_valid;
    logic [3:0]         control_out;
    logic [NumIrqs-1:0] irq_raise;
    logic [NumIrqs-1:0] irq_lower;
  } result_t;

  function automatic logic [NumIrqs-1:0] irq_bit(input logic [SlotW-1:0] slot);
    logic [NumIrqs-1:0] mask;
    mask = '0;
    if (int'(slot) < NumIrqs) begin
      mask[slot] = 1'b1;
    end
    return mask;
  endfunction

endpackage

>>> rtl/pc_parallel_port_block_unit.sv
// Bank of up to three PC printer ports on an I/O bus.
// Each input word on the slave stream is one command: an I/O write, an I/O
// read, a tick or a device interrupt line change. The command travels in
// tuser, the address, write byte, device pins, slot index and line level in
// tdata. Every input word yields exactly one output word on the master
// stream carrying the handled flag, read byte, data and control bytes sent
// to the device and the IRQ raise and lower masks.
// The number of present ports is set through the configuration write port; the user
// must do so only while the block is idle, which the block itself does not enforce.
// The result is computed from the input word and the per-port state and lands
// in the output register at the accepting edge.
// Throughput is one word per cycle, limited only by the output register.
// When the receiver stalls, the output register holds its word and the
// slave side is held off until it is taken.
// Reset clears all port state, the port count and the output register.
module pc_parallel_port_block_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,      // num_ports
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: io_address, write_data, status_pins, control_pins_in,
  // device_index, irq_level, zero pad
  input  logic [39:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,     // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: handled, read_data, data_out_valid, data_out, control_out_valid,
  // control_out, irq_raise, irq_lower, zero pad
  output logic [31:0] m_axis_tdata
);
  import ppb_pkg::*;

  logic [CfgW-1:0] num_ports_q;
  logic [7:0]      latched_q   [PortSlots];
  logic [7:0]      latched_d   [PortSlots];
  logic [1:0]      kept_q      [PortSlots];
  logic [1:0]      kept_d      [PortSlots];
  logic            enable_q    [PortSlots];
  logic            enable_d    [PortSlots];
  logic            pending_q   [PortSlots];
  logic            pending_d   [PortSlots];
  logic            delivered_q [PortSlots];
  logic            delivered_d [PortSlots];

  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    accept;

  cmd_e             cmd;
  logic [15:0]      io_address;
  logic [7:0]       write_data;
  logic [7:0]       status_pins;
  logic [3:0]       control_pins_in;
  logic [SlotW-1:0] device_index;
  logic             irq_level;
  dec_t             dec;

  assign cmd             = cmd_e'(s_axis_tuser);
  assign io_address      = s_axis_tdata[15:0];
  assign write_data      = s_axis_tdata[23:16];
  assign status_pins     = s_axis_tdata[31:24];
  assign control_pins_in = s_axis_tdata[35:32];
  assign device_index    = s_axis_tdata[37:36];
  assign irq_level       = s_axis_tdata[38];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ppb_decode u_decode (
    .io_address_i (io_address),
    .num_ports_i  (num_ports_q),
    .dec_o        (dec)
  );

  always_comb begin
    res = '0;
    for (int i = 0; i < PortSlots; i++) begin
      latched_d[i]   = latched_q[i];
      kept_d[i]      = kept_q[i];
      enable_d[i]    = enable_q[i];
      pending_d[i]   = pending_q[i];
      delivered_d[i] = delivered_q[i];
    end
    unique case (cmd)
      CMD_IO_WRITE: begin
        if (dec.hit) begin
          if (dec.offset == REG_DATA) begin
            res.handled        = 1'b1;
            res.data_out_valid = 1'b1;
            res.data_out       = write_data;
            if (delivered_q[dec.slot]) begin
              res.irq_lower = irq_bit(dec.slot);
            end
            latched_d[dec.slot] = write_data;
          end else if (dec.offset == REG_CONTROL) begin
            res.handled           = 1'b1;
            res.control_out_valid = 1'b1;
            res.control_out       = write_data[3:0];
            kept_d[dec.slot]      = write_data[5:4];
            enable_d[dec.slot]    = write_data[4];
          end
        end
      end
      CMD_IO_READ: begin
        if (dec.hit) begin
          if (dec.offset == REG_DATA) begin
            res.handled   = 1'b1;
            res.read_data = latched_q[dec.slot];
          end else if (dec.offset == REG_STATUS) begin
            res.handled   = 1'b1;
            res.read_data = {status_pins[7:3], ~pending_q[dec.slot], status_pins[1:0]};
            delivered_d[dec.slot] = 1'b0;
          end else if (dec.offset == REG_CONTROL) begin
            res.handled   = 1'b1;
            res.read_data = {2'b00, kept_q[dec.slot], control_pins_in};
          end
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < PortSlots; i++) begin
          if (CfgW'(i) < num_ports_q && enable_q[i] && pending_q[i] && !delivered_q[i]) begin
            res.irq_raise  = res.irq_raise | irq_bit(SlotW'(i));
            delivered_d[i] = 1'b1;
          end
        end
      end
      CMD_DEV_LINE: begin
        pending_d[device_index] = irq_level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ports_q <= '0;
    end else if (cfg_we_i) begin
      num_ports_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PortSlots; i++) begin
        latched_q[i]   <= '0;
        kept_q[i]      <= '0;
        enable_q[i]    <= 1'b0;
        pending_q[i]   <= 1'b0;
        delivered_q[i] <= 1'b0;
      end
    end else if (accept) begin
      for (int i = 0; i < PortSlots; i++) begin
        latched_q[i]   <= latched_d[i];
        kept_q[i]      <= kept_d[i];
        enable_q[i]    <= enable_d[i];
        pending_q[i]   <= pending_d[i];
        delivered_q[i] <= delivered_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
      if (s_axis_tvalid) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.irq_lower, out_q.irq_raise, out_q.control_out,
                          out_q.control_out_valid, out_q.data_out, out_q.data_out_valid,
                          out_q.read_data, out_q.handled};

endmodule

>>> rtl/ppb_decode.sv
module ppb_decode (
  input  logic [15:0]              io_address_i,
  input  logic [ppb_pkg::CfgW-1:0] num_ports_i,
  output ppb_pkg::dec_t            dec_o
);
  import ppb_pkg::*;

  logic [7:0]       hi;
  logic [5:0]       mid;
  logic             found;
  logic [SlotW-1:0] slot;

  assign hi  = io_address_i[15:8];
  assign mid = io_address_i[7:2];

  always_comb begin
    found = 1'b0;
    slot  = '0;
    if (mid == MidPrimary && hi == HiPrimary) begin
      found = 1'b1;
      slot  = SlotW'(0);
    end else if (mid == MidPrimary && hi == HiSecondary) begin
      found = 1'b1;
      slot  = SlotW'(1);
    end else if (mid == MidMono && hi == HiPrimary) begin
      found = 1'b1;
      slot  = SlotW'(2);
    end
  end

  assign dec_o.hit    = found && (CfgW'(slot) < num_ports_i);
  assign dec_o.slot   = slot;
  assign dec_o.offset = reg_e'(io_address_i[1:0]);

endmodule
